/* hdl/dual_buffer_flash_page_cache_assert.svh */
// Assertion helpers for the page cache. Expect clk and rst_n in scope.
`ifndef DUAL_BUFFER_FLASH_PAGE_CACHE_ASSERT_SVH
`define DUAL_BUFFER_FLASH_PAGE_CACHE_ASSERT_SVH

// Same-cycle implication.
`define DBFPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbfpc: assertion failed");

// Next-cycle implication.
`define DBFPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbfpc: assertion failed");

`endif

/* hdl/dbfpc_pkg.sv */
package dbfpc_pkg;

    // Geometry
    localparam int PAGE_BYTES   = 256;
    localparam int DEVICE_BYTES = 524288;
    localparam int MAX_REQUEST  = 4096;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 19;
    localparam int LEN_W  = 13;
    localparam int KIND_W = 3;
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int TAG_W  = ADDR_W - PAGE_W;
    localparam int CNT_W  = 9;
    localparam int DOFF_W = 12;

    // Shared adder width: holds address + length and the device size
    localparam int ALU_W = $clog2(DEVICE_BYTES) + 1;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

    // Flash command kinds
    localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] K_MREAD  = 3'd1;
    localparam logic [KIND_W-1:0] K_BREAD  = 3'd2;
    localparam logic [KIND_W-1:0] K_BWRITE = 3'd3;
    localparam logic [KIND_W-1:0] K_PROGE  = 3'd4;
    localparam logic [KIND_W-1:0] K_PROG   = 3'd5;
    localparam logic [KIND_W-1:0] K_FETCH  = 3'd6;

    // Sequencer -> buffer state updates
    typedef struct packed {
        logic             flip;
        logic             inval;
        logic             fill;
        logic             set_dirty;
        logic             clean;
        logic             idx;
        logic [TAG_W-1:0] tag;
    } buf_cmd_t;

    // Buffer state -> sequencer
    typedef struct packed {
        logic [1:0]            valid;
        logic [1:0]            live;
        logic [1:0][TAG_W-1:0] tag;
        logic                  hit;
        logic                  hit_idx;
        logic                  free_ok;
        logic                  free_idx;
        logic                  miss_flip;
        logic                  victim_idx;
    } buf_stat_t;

endpackage

/* hdl/dual_buffer_flash_page_cache.sv */
// Two-buffer write-back page cache front end for a serial page flash. Each
// item is a read, write or sync request; the block answers with the list of
// page-level flash commands (main read, buffer read, buffer write, program,
// fetch) that carry it out, the final one flagged by last. The block holds
// one item at a time: in_stall is high from acceptance until the sequencer
// has queued the last command. A read or write first runs the range checks
// (sum, device bound, maximum length, start address), then for each page
// piece sizes it (room, size) and issues a read, or for a write that hits
// does a lookup and a buffer write, or for a write miss a lookup, fetch and
// buffer write (a victim program goes out in the lookup step itself), and
// steps to the next page unless the piece is the last. Every step that
// issues a command also waits for the output register to be free. A range
// error or an empty read or write runs the range checks and then gives one
// empty answer. The pace is set by the single shared adder/subtractor that
// does the range checks and the piece bookkeeping one operation a cycle.
// erase_before_program must be written by the user through cfg_write_enable/cfg_write_data
// only while idle; the block itself does not enforce this. It picks program with erase or plain program.
`include "dual_buffer_flash_page_cache_assert.svh"

module dual_buffer_flash_page_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write_enable,
    input  logic                          cfg_write_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dbfpc_pkg::CMD_W-1:0]   cmd,
    input  logic [dbfpc_pkg::ADDR_W-1:0]  address,
    input  logic [dbfpc_pkg::LEN_W-1:0]   length,
    // command channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [dbfpc_pkg::KIND_W-1:0]  kind,
    output logic                          buffer_index,
    output logic [dbfpc_pkg::TAG_W-1:0]   page_number,
    output logic [dbfpc_pkg::PAGE_W-1:0]  page_offset,
    output logic [dbfpc_pkg::CNT_W-1:0]   byte_count,
    output logic [dbfpc_pkg::DOFF_W-1:0]  data_offset,
    output logic                          last
);

    localparam int ALU_W = dbfpc_pkg::ALU_W;
    localparam int TAG_W = dbfpc_pkg::TAG_W;
    localparam int PAGE_W = dbfpc_pkg::PAGE_W;
    localparam int LEN_W = dbfpc_pkg::LEN_W;
    localparam int CNT_W = dbfpc_pkg::CNT_W;
    localparam int KIND_W = dbfpc_pkg::KIND_W;
    localparam int DOFF_W = dbfpc_pkg::DOFF_W;
    localparam int ADDR_W_LOC = dbfpc_pkg::ADDR_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHK_SUM = 4'd1;
    localparam logic [3:0] S_CHK_DEV = 4'd2;
    localparam logic [3:0] S_CHK_MAX = 4'd3;
    localparam logic [3:0] S_CHK_ADR = 4'd4;
    localparam logic [3:0] S_EMPTY   = 4'd5;
    localparam logic [3:0] S_ROOM    = 4'd6;
    localparam logic [3:0] S_SIZE    = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;
    localparam logic [3:0] S_WLOOK   = 4'd9;
    localparam logic [3:0] S_FETCH   = 4'd10;
    localparam logic [3:0] S_WRITE   = 4'd11;
    localparam logic [3:0] S_ADV     = 4'd12;
    localparam logic [3:0] S_SYNC0   = 4'd13;
    localparam logic [3:0] S_SYNC1   = 4'd14;

    logic [3:0]             state_reg, state_next;
    logic                   erase_reg;
    logic                   is_write_reg, is_write_next;
    logic                   err_reg, err_next;
    logic [ADDR_W_LOC-1:0]  addr_reg, addr_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0]       done_reg, done_next;
    logic [TAG_W-1:0]       page_reg, page_next;
    logic [PAGE_W-1:0]      po_reg, po_next;
    logic [CNT_W-1:0]       room_reg, room_next;
    logic [CNT_W-1:0]       nb_reg, nb_next;
    logic                   lastp_reg, lastp_next;
    logic                   sel_reg, sel_next;
    logic [ALU_W-1:0]       tmp_reg, tmp_next;

    // output register
    logic                   ovalid_reg, ovalid_next;
    logic                   ostatus_reg;
    logic [KIND_W-1:0]      okind_reg;
    logic                   oidx_reg;
    logic [TAG_W-1:0]       opage_reg;
    logic [PAGE_W-1:0]      opo_reg;
    logic [CNT_W-1:0]       ocnt_reg;
    logic [DOFF_W-1:0]      odoff_reg;
    logic                   olast_reg;

    // command being issued this cycle
    logic                   emit;
    logic                   emit_ok;
    logic                   e_status;
    logic [KIND_W-1:0]      e_kind;
    logic                   e_idx;
    logic [TAG_W-1:0]       e_page;
    logic [PAGE_W-1:0]      e_po;
    logic [CNT_W-1:0]       e_cnt;
    logic [DOFF_W-1:0]      e_doff;
    logic                   e_last;

    logic [ALU_W-1:0]       alu_a, alu_b, alu_res;
    logic                   alu_sub, alu_neg;

    dbfpc_pkg::buf_cmd_t    bcmd;
    dbfpc_pkg::buf_stat_t   bstat;

    logic [KIND_W-1:0]      prog_kind;
    logic                   in_accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_ok   = !ovalid_reg || !out_stall;
    assign prog_kind = erase_reg ? dbfpc_pkg::K_PROGE : dbfpc_pkg::K_PROG;

    dbfpc_alu #(
        .W (ALU_W)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res),
        .neg (alu_neg)
    );

    dbfpc_bufs u_bufs (
        .clk   (clk),
        .rst_n (rst_n),
        .page  (page_reg),
        .cmd   (bcmd),
        .stat  (bstat)
    );

    // Operand steering for the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_CHK_SUM:
            begin
                alu_a = ALU_W'(addr_reg);
                alu_b = ALU_W'(len_reg);
            end
            S_CHK_DEV:
            begin
                alu_a   = ALU_W'(dbfpc_pkg::DEVICE_BYTES);
                alu_b   = tmp_reg;
                alu_sub = 1'b1;
            end
            S_CHK_MAX:
            begin
                alu_a   = ALU_W'(dbfpc_pkg::MAX_REQUEST);
                alu_b   = ALU_W'(len_reg);
                alu_sub = 1'b1;
            end
            S_CHK_ADR:
            begin
                alu_a   = ALU_W'(addr_reg);
                alu_b   = ALU_W'(dbfpc_pkg::DEVICE_BYTES);
                alu_sub = 1'b1;
            end
            S_ROOM:
            begin
                alu_a   = ALU_W'(dbfpc_pkg::PAGE_BYTES);
                alu_b   = ALU_W'(po_reg);
                alu_sub = 1'b1;
            end
            S_SIZE:
            begin
                alu_a   = ALU_W'(rem_reg);
                alu_b   = ALU_W'(room_reg);
                alu_sub = 1'b1;
            end
            S_ADV:
            begin
                alu_a = ALU_W'(done_reg);
                alu_b = ALU_W'(nb_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        is_write_next = is_write_reg;
        err_next      = err_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        done_next     = done_reg;
        page_next     = page_reg;
        po_next       = po_reg;
        room_next     = room_reg;
        nb_next       = nb_reg;
        lastp_next    = lastp_reg;
        sel_next      = sel_reg;
        tmp_next      = tmp_reg;

        emit     = 1'b0;
        e_status = 1'b0;
        e_kind   = dbfpc_pkg::K_NONE;
        e_idx    = 1'b0;
        e_page   = '0;
        e_po     = '0;
        e_cnt    = '0;
        e_doff   = '0;
        e_last   = 1'b0;

        bcmd     = '0;
        bcmd.tag = page_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    is_write_next = (cmd == dbfpc_pkg::CMD_WRITE);
                    err_next      = 1'b0;
                    addr_next     = address;
                    len_next      = length;
                    rem_next      = length;
                    done_next     = '0;
                    page_next     = address[ADDR_W_LOC-1:PAGE_W];
                    po_next       = address[PAGE_W-1:0];
                    if ((cmd != dbfpc_pkg::CMD_READ) && (cmd != dbfpc_pkg::CMD_WRITE))
                    begin
                        state_next = S_SYNC0;
                    end
                    else
                    begin
                        state_next = S_CHK_SUM;
                    end
                end
            end
            S_CHK_SUM:
            begin
                tmp_next   = alu_res;
                state_next = S_CHK_DEV;
            end
            S_CHK_DEV:
            begin
                err_next   = err_reg | alu_neg;     // address + length beyond device
                state_next = S_CHK_MAX;
            end
            S_CHK_MAX:
            begin
                err_next   = err_reg | alu_neg;     // length too long
                state_next = S_CHK_ADR;
            end
            S_CHK_ADR:
            begin
                err_next = err_reg | !alu_neg;      // start at or past device end
                if (err_next || (len_reg == '0))
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    state_next = S_ROOM;
                end
            end
            S_EMPTY:
            begin
                emit     = 1'b1;
                e_status = err_reg;
                e_last   = 1'b1;
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOM:
            begin
                room_next  = alu_res[CNT_W-1:0];
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                if (alu_neg)
                begin
                    nb_next    = rem_reg[CNT_W-1:0];
                    lastp_next = 1'b1;
                end
                else
                begin
                    nb_next    = room_reg;
                    rem_next   = alu_res[LEN_W-1:0];
                    lastp_next = (alu_res == '0);
                end
                state_next = is_write_reg ? S_WLOOK : S_READ;
            end
            S_READ:
            begin
                emit   = 1'b1;
                e_kind = bstat.hit ? dbfpc_pkg::K_BREAD : dbfpc_pkg::K_MREAD;
                e_idx  = bstat.hit & bstat.hit_idx;
                e_page = page_reg;
                e_po   = po_reg;
                e_cnt  = nb_reg;
                e_doff = done_reg[DOFF_W-1:0];
                e_last = lastp_reg;
                if (emit_ok)
                begin
                    state_next = lastp_reg ? S_IDLE : S_ADV;
                end
            end
            S_WLOOK:
            begin
                if (bstat.hit)
                begin
                    sel_next   = bstat.hit_idx;
                    state_next = S_WRITE;
                end
                else if (bstat.free_ok)
                begin
                    bcmd.flip  = bstat.miss_flip;
                    sel_next   = bstat.free_idx;
                    state_next = S_FETCH;
                end
                else
                begin
                    // both dirty: program the victim and drop it
                    emit   = 1'b1;
                    e_kind = prog_kind;
                    e_idx  = bstat.victim_idx;
                    e_page = bstat.tag[bstat.victim_idx];
                    if (emit_ok)
                    begin
                        bcmd.flip  = 1'b1;
                        bcmd.inval = 1'b1;
                        bcmd.idx   = bstat.victim_idx;
                        sel_next   = bstat.victim_idx;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                emit   = 1'b1;
                e_kind = dbfpc_pkg::K_FETCH;
                e_idx  = sel_reg;
                e_page = page_reg;
                if (emit_ok)
                begin
                    bcmd.fill  = 1'b1;
                    bcmd.idx   = sel_reg;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                emit   = 1'b1;
                e_kind = dbfpc_pkg::K_BWRITE;
                e_idx  = sel_reg;
                e_page = page_reg;
                e_po   = po_reg;
                e_cnt  = nb_reg;
                e_doff = done_reg[DOFF_W-1:0];
                e_last = lastp_reg;
                if (emit_ok)
                begin
                    bcmd.set_dirty = 1'b1;
                    bcmd.idx       = sel_reg;
                    state_next     = lastp_reg ? S_IDLE : S_ADV;
                end
            end
            S_ADV:
            begin
                done_next  = alu_res[LEN_W-1:0];
                page_next  = page_reg + TAG_W'(1);
                po_next    = '0;
                state_next = S_ROOM;
            end
            S_SYNC0:
            begin
                if (bstat.live[0])
                begin
                    emit   = 1'b1;
                    e_kind = prog_kind;
                    e_page = bstat.tag[0];
                    e_last = !bstat.live[1];
                    if (emit_ok)
                    begin
                        bcmd.clean = 1'b1;
                        state_next = bstat.live[1] ? S_SYNC1 : S_IDLE;
                    end
                end
                else if (bstat.live[1])
                begin
                    state_next = S_SYNC1;
                end
                else
                begin
                    // nothing dirty: lone empty answer
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (emit_ok)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SYNC1:
            begin
                emit   = 1'b1;
                e_kind = prog_kind;
                e_idx  = 1'b1;
                e_page = bstat.tag[1];
                e_last = 1'b1;
                if (emit_ok)
                begin
                    bcmd.clean = 1'b1;
                    bcmd.idx   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a command waits here while the sequencer moves on
    always_comb
    begin
        if (emit && emit_ok)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            erase_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_write_enable)
            begin
                erase_reg <= cfg_write_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        is_write_reg <= is_write_next;
        err_reg      <= err_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        done_reg     <= done_next;
        page_reg     <= page_next;
        po_reg       <= po_next;
        room_reg     <= room_next;
        nb_reg       <= nb_next;
        lastp_reg    <= lastp_next;
        sel_reg      <= sel_next;
        tmp_reg      <= tmp_next;
        if (emit && emit_ok)
        begin
            ostatus_reg <= e_status;
            okind_reg   <= e_kind;
            oidx_reg    <= e_idx;
            opage_reg   <= e_page;
            opo_reg     <= e_po;
            ocnt_reg    <= e_cnt;
            odoff_reg   <= e_doff;
            olast_reg   <= e_last;
        end
    end

    assign out_valid    = ovalid_reg;
    assign status       = ostatus_reg;
    assign kind         = okind_reg;
    assign buffer_index = oidx_reg;
    assign page_number  = opage_reg;
    assign page_offset  = opo_reg;
    assign byte_count   = ocnt_reg;
    assign data_offset  = odoff_reg;
    assign last         = olast_reg;

    // A command still pending while idle must be the request's final one
    `DBFPC_ASSERT_IMPL(a_idle_pending_last, (state_reg == S_IDLE) && ovalid_reg, olast_reg)
    // A buffer write always targets a buffer that now holds the page
    `DBFPC_ASSERT_IMPL(a_write_hits, (state_reg == S_WRITE), bstat.hit && (bstat.hit_idx == sel_reg))
    // The two buffers never cache the same page
    `DBFPC_ASSERT_IMPL(a_tags_unique, bstat.valid[0] && bstat.valid[1], bstat.tag[0] != bstat.tag[1])
    // An accepted item holds the block busy in the next cycle
    `DBFPC_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall)

endmodule

/* hdl/dbfpc_alu.sv */
// Shared add/subtract unit; neg is the borrow of a subtract.
module dbfpc_alu #(
    parameter int W = dbfpc_pkg::ALU_W
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] res,
    output logic         neg
);

    logic [W:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign res = full[W-1:0];
    assign neg = sub & full[W];

endmodule

/* hdl/dbfpc_bufs.sv */
// Two page buffers: tags, valid/dirty marks, victim toggle, lookup.
module dbfpc_bufs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dbfpc_pkg::TAG_W-1:0] page,
    input  dbfpc_pkg::buf_cmd_t        cmd,
    output dbfpc_pkg::buf_stat_t       stat
);

    logic [1:0][dbfpc_pkg::TAG_W-1:0] tag_reg;
    logic [1:0]                       valid_reg;
    logic [1:0]                       dirty_reg;
    logic                             toggle_reg;

    logic hit0;
    logic hit1;
    logic t;
    logic free_first;
    logic free_second;

    assign hit0 = valid_reg[0] && (tag_reg[0] == page);
    assign hit1 = valid_reg[1] && (tag_reg[1] == page);
    assign t    = toggle_reg;

    // free = empty or clean; toggle is checked first, then the other one
    assign free_first  = !valid_reg[t] || !dirty_reg[t];
    assign free_second = !valid_reg[~t] || !dirty_reg[~t];

    always_comb
    begin
        stat.valid      = valid_reg;
        stat.live       = valid_reg & dirty_reg;
        stat.tag        = tag_reg;
        stat.hit        = hit0 | hit1;
        stat.hit_idx    = !hit0;
        stat.free_ok    = free_first | free_second;
        stat.free_idx   = free_first ? t : ~t;
        // one check flips once, two checks cancel, a full miss nets one flip
        stat.miss_flip  = free_first | !free_second;
        stat.victim_idx = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg    <= '0;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            toggle_reg <= 1'b0;
        end
        else
        begin
            if (cmd.flip)
            begin
                toggle_reg <= ~toggle_reg;
            end
            if (cmd.inval)
            begin
                valid_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.fill)
            begin
                tag_reg[cmd.idx]   <= cmd.tag;
                valid_reg[cmd.idx] <= 1'b1;
                dirty_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.set_dirty)
            begin
                dirty_reg[cmd.idx] <= 1'b1;
            end
            if (cmd.clean)
            begin
                dirty_reg[cmd.idx] <= 1'b0;
            end
        end
    end

endmodule

/* test/dual_buffer_flash_page_cache_checker.sv */
module dual_buffer_flash_page_cache_checker
    import dbfpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_enable,
    input  logic              cfg_write_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              status,
    input  logic [KIND_W-1:0] kind,
    input  logic              buffer_index,
    input  logic [TAG_W-1:0]  page_number,
    input  logic [PAGE_W-1:0] page_offset,
    input  logic [CNT_W-1:0]  byte_count,
    input  logic [DOFF_W-1:0] data_offset,
    input  logic              last,
    output int                outstanding,
    output int                mismatch_count
);

    typedef struct packed {
        logic              status;
        logic [KIND_W-1:0] kind;
        logic              buf_idx;
        logic [TAG_W-1:0]  page;
        logic [PAGE_W-1:0] offset;
        logic [CNT_W-1:0]  count;
        logic [DOFF_W-1:0] doff;
        logic              last;
    } flash_cmd_t;

    // shadow copy of the cache state
    logic [TAG_W-1:0] buf_tag [2];
    logic [1:0]       buf_valid;
    logic [1:0]       buf_dirty;
    logic             victim_sel;
    logic             erase_mode;

    flash_cmd_t expected_cmds [$];

    function automatic flash_cmd_t flash_cmd(input logic st, input logic [KIND_W-1:0] k,
                                             input logic b, input int pg, input int off,
                                             input int cnt, input int doff);
        flash_cmd_t c;
        c.status  = st;
        c.kind    = k;
        c.buf_idx = b;
        c.page    = TAG_W'(pg);
        c.offset  = PAGE_W'(off);
        c.count   = CNT_W'(cnt);
        c.doff    = DOFF_W'(doff);
        c.last    = 1'b0;
        return c;
    endfunction

    function automatic logic [KIND_W-1:0] program_kind();
        return erase_mode ? K_PROGE : K_PROG;
    endfunction

    // Works out the command list for one request and updates the shadow state.
    task automatic plan_flash_commands(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                       input logic [LEN_W-1:0] len);
        flash_cmd_t plan [$];
        int page;
        int po;
        int done;
        int nb;
        int bi;
        int k;
        if (c != CMD_READ && c != CMD_WRITE) begin
            for (int i = 0; i < 2; i++) begin
                if (buf_valid[i] && buf_dirty[i]) begin
                    plan.push_back(flash_cmd(1'b0, program_kind(), i[0], buf_tag[i], 0, 0, 0));
                    buf_dirty[i] = 1'b0;
                end
            end
        end else if (int'(a) >= DEVICE_BYTES || int'(a) + int'(len) > DEVICE_BYTES
                     || int'(len) > MAX_REQUEST) begin
            plan.push_back(flash_cmd(1'b1, K_NONE, 1'b0, 0, 0, 0, 0));
        end else if (len != 0) begin
            page = int'(a) / PAGE_BYTES;
            po   = int'(a) % PAGE_BYTES;
            done = 0;
            while (done < int'(len)) begin
                nb = PAGE_BYTES - po;
                if (nb > int'(len) - done)
                    nb = int'(len) - done;
                bi = -1;
                if (buf_valid[0] && buf_tag[0] == TAG_W'(page))
                    bi = 0;
                else if (buf_valid[1] && buf_tag[1] == TAG_W'(page))
                    bi = 1;
                if (c == CMD_READ) begin
                    if (bi < 0)
                        plan.push_back(flash_cmd(1'b0, K_MREAD, 1'b0, page, po, nb, done));
                    else
                        plan.push_back(flash_cmd(1'b0, K_BREAD, bi[0], page, po, nb, done));
                end else begin
                    if (bi < 0) begin
                        // each buffer looked at flips the toggle
                        for (int i = 0; i < 2; i++) begin
                            if (bi < 0) begin
                                k = victim_sel;
                                victim_sel = ~victim_sel;
                                if (!buf_valid[k] || !buf_dirty[k])
                                    bi = k;
                            end
                        end
                        if (bi < 0) begin
                            // both dirty: program the victim and drop it
                            bi = victim_sel;
                            victim_sel = ~victim_sel;
                            plan.push_back(flash_cmd(1'b0, program_kind(), bi[0],
                                                     buf_tag[bi], 0, 0, 0));
                            buf_valid[bi] = 1'b0;
                        end
                        plan.push_back(flash_cmd(1'b0, K_FETCH, bi[0], page, 0, 0, 0));
                        buf_tag[bi]   = TAG_W'(page);
                        buf_valid[bi] = 1'b1;
                        buf_dirty[bi] = 1'b0;
                    end
                    plan.push_back(flash_cmd(1'b0, K_BWRITE, bi[0], page, po, nb, done));
                    buf_dirty[bi] = 1'b1;
                end
                done += nb;
                page++;
                po = 0;
            end
        end
        if (plan.size() == 0)
            plan.push_back(flash_cmd(1'b0, K_NONE, 1'b0, 0, 0, 0, 0));
        plan[plan.size()-1].last = 1'b1;
        foreach (plan[i])
            expected_cmds.push_back(plan[i]);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        flash_cmd_t want;
        if (!rst_n) begin
            buf_tag[0]     = '0;
            buf_tag[1]     = '0;
            buf_valid      = '0;
            buf_dirty      = '0;
            victim_sel     = 1'b0;
            erase_mode     = 1'b1;
            mismatch_count = 0;
            expected_cmds.delete();
            outstanding   <= 0;
        end else begin
            if (cfg_write_enable)
                erase_mode = cfg_write_data;
            if (in_valid && !in_stall)
                plan_flash_commands(cmd, address, length);
            if (out_valid && !out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected command: kind %0d page %0d", kind, page_number);
                    mismatch_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("kind", want.kind, kind);
                    compare_field("buffer_index", want.buf_idx, buffer_index);
                    compare_field("page_number", want.page, page_number);
                    compare_field("page_offset", want.offset, page_offset);
                    compare_field("byte_count", want.count, byte_count);
                    compare_field("data_offset", want.doff, data_offset);
                    compare_field("last", want.last, last);
                end
            end
            outstanding <= expected_cmds.size();
        end
    end

endmodule

/* test/tb_dual_buffer_flash_page_cache.sv */
module tb_dual_buffer_flash_page_cache;
    import dbfpc_pkg::*;

    // sync codes; the block treats the spare code as sync too
    localparam logic [CMD_W-1:0] CMD_SYNC     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SYNC_ALT = 2'd3;

    // erase_before_program settings
    localparam logic ERASE_ON  = 1'b1;
    localparam logic ERASE_OFF = 1'b0;

    // items per random phase, receiver hold-off, settle time after a drain
    localparam int PHASE_ITEMS    = 58;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TIMEOUT        = 10_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_enable = 1'b0;
    logic              cfg_write_data = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd = CMD_READ;
    logic [ADDR_W-1:0] address = '0;
    logic [LEN_W-1:0]  length = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              status;
    logic [KIND_W-1:0] kind;
    logic              buffer_index;
    logic [TAG_W-1:0]  page_number;
    logic [PAGE_W-1:0] page_offset;
    logic [CNT_W-1:0]  byte_count;
    logic [DOFF_W-1:0] data_offset;
    logic              last;

    int outstanding;
    int mismatches;

    // pacing knobs, written by the stimulus process at a rising edge only
    int gap_pct   = 0;
    int stall_pct = 0;
    bit want_holdoff = 1'b0;
    // written by the receiver process only
    bit holdoff_done = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dual_buffer_flash_page_cache DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .address          (address),
        .length           (length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .kind             (kind),
        .buffer_index     (buffer_index),
        .page_number      (page_number),
        .page_offset      (page_offset),
        .byte_count       (byte_count),
        .data_offset      (data_offset),
        .last             (last)
    );

    // Watches both channels, predicts every flash command and compares.
    dual_buffer_flash_page_cache_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .address          (address),
        .length           (length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .kind             (kind),
        .buffer_index     (buffer_index),
        .page_number      (page_number),
        .page_offset      (page_offset),
        .byte_count       (byte_count),
        .data_offset      (data_offset),
        .last             (last),
        .outstanding      (outstanding),
        .mismatch_count   (mismatches)
    );

    // Receiver: random stall each cycle, plus one long hold-off on request so
    // the output register backs up and the block stalls its request side.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (want_holdoff && !holdoff_done)
            begin
                out_stall = 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_done = 1'b1;
            end
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Change the pacing at a rising edge so the receiver's falling-edge draw
    // never races with the update. Returns at a falling edge.
    task automatic set_pace(input int gap, input int stall, input bit holdoff);
        @(posedge clk);
        gap_pct      = gap;
        stall_pct    = stall;
        want_holdoff = holdoff;
        @(negedge clk);
    endtask

    // Offer one item. Entered and left at a falling edge. in_valid stays high
    // straight into the next item when no idle cycles are drawn.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                             input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = c;
        address  = a;
        length   = len;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Sender pauses until every predicted command has come out.
    task automatic drain();
        in_valid = 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_erase_mode(input logic value);
        cfg_write_enable = 1'b1;
        cfg_write_data   = value;
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    // Random request. Most addresses fall on a handful of pages so buffer hits,
    // clean misses and victim programs all happen; a share uses the full
    // address range and full length range for bit coverage and range errors.
    task automatic random_item();
        logic [CMD_W-1:0]  c;
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  len;
        int                r;
        r = $urandom_range(99);
        if (r < 40)
            c = CMD_READ;
        else if (r < 80)
            c = CMD_WRITE;
        else if (r < 92)
            c = CMD_SYNC;
        else
            c = CMD_SYNC_ALT;
        r = $urandom_range(99);
        if (r < 25)
            a = ADDR_W'($urandom);
        else if (r < 40)
            a = {TAG_W'(2047 - $urandom_range(3)), PAGE_W'($urandom)};
        else
            a = {TAG_W'($urandom_range(5)), PAGE_W'($urandom)};
        r = $urandom_range(99);
        if (r < 55)
            len = LEN_W'($urandom_range(300, 1));
        else if (r < 80)
            len = LEN_W'($urandom_range(1200, 301));
        else if (r < 88)
            len = LEN_W'($urandom_range(MAX_REQUEST, 1201));
        else if (r < 93)
            len = '0;
        else if (r < 97)
            len = LEN_W'($urandom_range(8191, MAX_REQUEST + 1));
        else
            len = LEN_W'($urandom);
        send_item(c, a, len);
    endtask

    // Stimulus
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_pace(0, 0, 1'b0);

        // directed part, program-with-erase from reset
        send_item(CMD_READ, 19'h00000, 13'd0);      // empty read
        send_item(CMD_SYNC, 19'h00000, 13'd0);      // sync with nothing dirty
        send_item(CMD_READ, 19'h00000, 13'd1);      // main read
        send_item(CMD_WRITE, 19'h00005, 13'd10);    // fetch into empty buffer 0
        send_item(CMD_READ, 19'h00000, 13'd256);    // buffer read, whole page
        send_item(CMD_WRITE, 19'h7FF00, 13'd256);   // top page into buffer 1
        send_item(CMD_WRITE, 19'h00200, 13'd1);     // both dirty: victim program
        send_item(CMD_SYNC, 19'h00000, 13'd0);
        send_item(CMD_SYNC_ALT, 19'h7FFFF, 13'h1FFF);
        send_item(CMD_WRITE, 19'h0012C, 13'd4096);  // longest request, many victims
        send_item(CMD_READ, 19'h7FFFF, 13'd1);      // last byte of the device
        send_item(CMD_READ, 19'h7FFFF, 13'd2);      // runs past the end
        send_item(CMD_READ, 19'h00000, 13'd4097);   // too long
        send_item(CMD_WRITE, 19'h7FFFF, 13'h1FFF);  // all ones
        send_item(CMD_WRITE, 19'h00000, 13'd0);     // empty write
        send_item(CMD_READ, 19'h000FA, 13'd20);     // straddles a page boundary
        drain();

        // plain program without erase
        write_erase_mode(ERASE_OFF);
        send_item(CMD_WRITE, 19'h40000, 13'd600);
        send_item(CMD_SYNC_ALT, 19'h00000, 13'd0);
        send_item(CMD_READ, 19'h55555, 13'h0AAA);
        drain();

        // random phases: no idling, sender idle, receiver stalling, both
        write_erase_mode(ERASE_ON);
        set_pace(0, 0, 1'b0);
        repeat (PHASE_ITEMS) random_item();
        drain();

        write_erase_mode(ERASE_OFF);
        set_pace(86, 0, 1'b0);
        repeat (PHASE_ITEMS) random_item();
        drain();

        write_erase_mode(ERASE_ON);
        set_pace(0, 86, 1'b0);
        repeat (PHASE_ITEMS) random_item();
        drain();

        write_erase_mode(ERASE_OFF);
        set_pace(25, 25, 1'b0);
        repeat (PHASE_ITEMS) random_item();
        drain();

        // receiver holds off while the sender keeps offering back to back
        write_erase_mode(ERASE_ON);
        set_pace(0, 0, 1'b1);
        repeat (PHASE_ITEMS) random_item();
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #TIMEOUT;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
